@@ hdl/mfe_pkg.sv @@
`default_nettype none
package mfe_pkg;

    // result status codes
    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN      = 2'd2;

    // register reset values
    localparam logic [31:0] START_MARKER_RST = 32'h1A2A3A4A;
    localparam logic [31:0] END_MARKER_RST   = 32'h1F2F3F4F;
    localparam logic [12:0] MAX_LEN_RST      = 13'd4096;

    // fresh bytes needed before a marker may match
    localparam logic [2:0] WINDOW_FULL = 3'd4;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] frame_status;
        logic       frame_last;
        logic [7:0] payload_byte;
    } result_t;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage
`default_nettype wire

@@ hdl/marker_frame_extractor_core.sv @@
`default_nettype none
// a result beat shows on the m_ side once it has passed the queue and then the output register
// throughput: one byte per cycle while the queue is not full; the window compare in the front end is combinational
// a four-entry queue and an output register let either side stall on its own
// reset: synchronous active-low aresetn clears the hunt state, the queue and the output,
// and returns the markers and the length limit to their default values
module marker_frame_extractor_core #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] payload_byte
    output logic             m_tlast,   // frame_last
    output logic [1:0]       m_tuser    // [1:0] frame_status
);
    import mfe_pkg::*;

    logic      in_beat;
    logic      push;
    result_t   push_data;
    logic      q_pop;
    result_t   q_data;
    q_status_t q_status;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;
    assign in_beat   = s_tvalid && s_tready;

    // classify incoming bytes
    mfe_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .in_byte   (s_tdata),
        .push      (push),
        .push_data (push_data)
    );

    // result queue
    mfe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    // output stage
    mfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ hdl/mfe_front.sv @@
`default_nettype none
module mfe_front #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    input  wire logic            in_beat,
    input  wire logic [7:0]      in_byte,
    output logic                 push,
    output mfe_pkg::result_t     push_data
);
    import mfe_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = (CW > 13) ? CW : 13;

    logic [31:0]   start_marker_reg;
    logic [31:0]   end_marker_reg;
    logic [12:0]   max_len_reg;

    logic          in_frame_reg, in_frame_next;
    logic [31:0]   recent_reg, recent_next;
    logic [2:0]    since_reg, since_next;
    logic [CW-1:0] count_reg, count_next;

    logic [7:0]    leaving;
    logic [2:0]    since_inc;
    logic          window_full;
    logic          full_now;
    logic          end_seen;
    logic [LW-1:0] max_ext;
    logic [LW-1:0] buf_lim;
    logic [LW-1:0] lim;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            max_len_reg      <= MAX_LEN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                CFG_MAX_LEN:      max_len_reg      <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // payload limit clamped to one and to the buffer size
    always_comb begin
        max_ext = LW'(max_len_reg);
        buf_lim = LW'(BUFFER_BYTES);
        if (max_len_reg == 13'd0) begin
            lim = LW'(1);
        end else if (max_ext > buf_lim) begin
            lim = buf_lim;
        end else begin
            lim = max_ext;
        end
    end

    // window shift and marker tests
    assign leaving     = recent_reg[31:24];
    assign recent_next = {recent_reg[23:0], in_byte};
    assign window_full = (since_reg == WINDOW_FULL);
    assign since_inc   = window_full ? since_reg : since_reg + 3'd1;
    assign full_now    = (since_inc == WINDOW_FULL);
    assign end_seen    = full_now && (recent_next == end_marker_reg);

    // classify the beat
    always_comb begin
        in_frame_next          = in_frame_reg;
        since_next             = since_inc;
        count_next             = count_reg;
        push                   = 1'b0;
        push_data.payload_byte = 8'd0;
        push_data.frame_last   = 1'b0;
        push_data.frame_status = STATUS_DATA;
        if (!in_frame_reg) begin
            if (full_now && recent_next == start_marker_reg) begin
                in_frame_next = 1'b1;
                since_next    = 3'd0;
                count_next    = '0;
            end
        end else if (window_full) begin
            push = 1'b1;
            if (LW'(count_reg) >= lim) begin
                in_frame_next          = 1'b0;
                since_next             = 3'd0;
                count_next             = '0;
                push_data.frame_last   = 1'b1;
                push_data.frame_status = STATUS_OVERFLOW;
            end else begin
                push_data.payload_byte = leaving;
                count_next             = count_reg + 1'b1;
                if (end_seen) begin
                    in_frame_next        = 1'b0;
                    since_next           = 3'd0;
                    count_next           = '0;
                    push_data.frame_last = 1'b1;
                end
            end
        end else if (end_seen) begin
            push                   = 1'b1;
            in_frame_next          = 1'b0;
            since_next             = 3'd0;
            count_next             = '0;
            push_data.frame_last   = 1'b1;
            push_data.frame_status = STATUS_EMPTY;
        end
        if (!in_beat) begin
            push = 1'b0;
        end
    end

    // deframer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            recent_reg   <= 32'd0;
            since_reg    <= 3'd0;
            count_reg    <= '0;
        end else if (in_beat) begin
            in_frame_reg <= in_frame_next;
            recent_reg   <= recent_next;
            since_reg    <= since_next;
            count_reg    <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mfe_queue.sv @@
`default_nettype none
module mfe_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  mfe_pkg::result_t   push_data,
    input  wire logic          pop,
    output mfe_pkg::result_t   pop_data,
    output mfe_pkg::q_status_t status
);
    import mfe_pkg::*;

    result_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == (QPTR_W + 1)'(QDEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // fill level
    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mfe_back.sv @@
`default_nettype none
module mfe_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  mfe_pkg::q_status_t q_status,
    input  mfe_pkg::result_t   q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);
    import mfe_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    load;

    // refill the output register when it is empty or being taken
    assign load  = !out_valid_reg || m_tready;
    assign q_pop = load && !q_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= !q_status.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg <= q_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.payload_byte;
    assign m_tlast  = out_data_reg.frame_last;
    assign m_tuser  = out_data_reg.frame_status;

endmodule
`default_nettype wire

@@ hdl/mfe_checker.sv @@
`default_nettype none
module mfe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [1:0] m_tuser
);
    import mfe_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // output comes up empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // empty and overflow results close the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_DATA |-> m_tlast)
        else $error("status result without last");

    // empty and overflow results carry no byte, and no unknown status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_DATA |->
            m_tdata == 8'd0 && (m_tuser == STATUS_EMPTY || m_tuser == STATUS_OVERFLOW))
        else $error("bad status result");

endmodule

bind marker_frame_extractor_core mfe_checker u_mfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/sv/tb_marker_frame_extractor_core.sv @@
`timescale 1ns / 1ps

module tb_marker_frame_extractor_core;

    import mfe_pkg::*;

    localparam int         BUF_BYTES  = 4096;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // clock and reset
    logic        aclk;
    logic        aresetn   = 1'b0;

    // dut ports
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] payload_byte
    logic        m_tlast;          // frame_last
    logic [1:0]  m_tuser;          // [1:0] frame_status

    // byte stream waiting to be driven and deframed results still owed
    logic [7:0]  tx_stream[$];
    result_t     expected_payload[$];
    int          n_queued  = 0;
    bit          no_idle   = 1'b0;

    // deframer state mirrored by the predictor
    logic        hunt_done;
    logic [31:0] window;
    logic [2:0]  fresh_cnt;
    logic [12:0] payload_cnt;
    logic [31:0] start_mk;
    logic [31:0] end_mk;
    logic [12:0] len_limit;

    // run statistics
    int          n_bytes   = 0;
    int          n_writes  = 0;
    int          n_data    = 0;
    int          n_empty   = 0;
    int          n_ovf     = 0;
    int          errors    = 0;
    int          src_wait  = 0;
    int          sink_wait = 0;

    marker_frame_extractor_core #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 14));
    endfunction

    // zero maps to one, anything above the buffer size clips to it
    function automatic int active_limit();
        if (len_limit == 13'd0)
            return 1;
        if (int'(len_limit) > BUF_BYTES)
            return BUF_BYTES;
        return int'(len_limit);
    endfunction

    function automatic void owe_result(input logic [7:0] pb, input logic lst,
                                       input logic [1:0] st);
        expected_payload.push_back('{frame_status: st, frame_last: lst, payload_byte: pb});
    endfunction

    function automatic void close_frame();
        hunt_done   = 1'b0;
        fresh_cnt   = '0;
        payload_cnt = '0;
    endfunction

    // one received byte through the window; owes at most one result
    function automatic void deframe_byte(input logic [7:0] rx);
        logic [7:0] leaving;
        logic       was_full;
        logic       full_now;
        logic       end_hit;
        leaving  = window[31:24];
        was_full = (fresh_cnt >= WINDOW_FULL);
        window   = {window[23:0], rx};
        if (fresh_cnt < WINDOW_FULL)
            fresh_cnt = fresh_cnt + 3'd1;
        full_now = (fresh_cnt >= WINDOW_FULL);
        if (!hunt_done) begin
            if (full_now && window == start_mk) begin
                hunt_done   = 1'b1;
                fresh_cnt   = '0;
                payload_cnt = '0;
            end
            return;
        end
        end_hit = full_now && (window == end_mk);
        if (was_full) begin
            if (int'(payload_cnt) >= active_limit()) begin
                close_frame();
                owe_result(8'h00, 1'b1, STATUS_OVERFLOW);
                return;
            end
            payload_cnt = payload_cnt + 13'd1;
            if (end_hit) begin
                close_frame();
                owe_result(leaving, 1'b1, STATUS_DATA);
            end else begin
                owe_result(leaving, 1'b0, STATUS_DATA);
            end
        end else if (end_hit) begin
            close_frame();
            owe_result(8'h00, 1'b1, STATUS_EMPTY);
        end
    endfunction

    // driver: register writes and input beats update the predictor as they are taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            src_wait    = 0;
            hunt_done   = 1'b0;
            window      = '0;
            fresh_cnt   = '0;
            payload_cnt = '0;
            start_mk    = START_MARKER_RST;
            end_mk      = END_MARKER_RST;
            len_limit   = MAX_LEN_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                n_writes++;
                case (cfg_index)
                    CFG_START_MARKER: start_mk = cfg_data;
                    CFG_END_MARKER:   end_mk = cfg_data;
                    CFG_MAX_LEN:      len_limit = cfg_data[12:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                n_bytes++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (tx_stream.size() != 0) begin
                    s_tdata  <= tx_stream.pop_front();
                    s_tvalid <= 1'b1;
                    src_wait = idle_draw();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: each result beat against the oldest owed result
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_payload.size() == 0) begin
                    $error("unexpected result beat: data %0h last %0b status %0d",
                           m_tdata, m_tlast, m_tuser);
                    errors++;
                end else begin
                    want = expected_payload.pop_front();
                    if (m_tdata !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h", want.payload_byte, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.frame_last) begin
                        $error("frame_last: expected %0b, got %0b", want.frame_last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.frame_status) begin
                        $error("frame_status: expected %0d, got %0d", want.frame_status, m_tuser);
                        errors++;
                    end
                    case (want.frame_status)
                        STATUS_DATA:  n_data++;
                        STATUS_EMPTY: n_empty++;
                        default:      n_ovf++;
                    endcase
                end
                sink_wait = idle_draw();
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void push_byte(input logic [7:0] b);
        tx_stream.push_back(b);
        n_queued++;
    endfunction

    // first n bytes of a marker, first received byte on top
    function automatic void push_marker(input logic [31:0] mk, input int n);
        for (int i = 0; i < n; i++)
            push_byte(mk[31 - 8 * i -: 8]);
    endfunction

    function automatic void push_noise(input int n);
        repeat (n) push_byte(8'($urandom));
    endfunction

    // mostly whole frames, some left open, partial markers and plain noise
    function automatic void add_segment(input logic [31:0] smk, input logic [31:0] emk,
                                        input int max_pay);
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            if ($urandom_range(0, 3) == 0)
                push_marker(smk, $urandom_range(1, 3));
            push_noise($urandom_range(0, 3));
            push_marker(smk, 4);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_pay) : $urandom_range(0, 8);
            push_noise(n);
            if ($urandom_range(0, 5) == 0)
                push_marker(emk, $urandom_range(1, 3));
            push_marker(emk, 4);
        end else if (kind == 7) begin
            push_marker(smk, 4);
            push_noise($urandom_range(0, 6));
        end else if (kind == 8) begin
            push_marker(smk, $urandom_range(1, 3));
            push_noise($urandom_range(1, 4));
        end else begin
            push_noise($urandom_range(1, 8));
        end
    endfunction

    function automatic void fill_random(input int n, input logic [31:0] smk,
                                        input logic [31:0] emk, input int max_pay);
        int first;
        first = n_queued;
        while (n_queued - first < n)
            add_segment(smk, emk, max_pay);
    endfunction

    // wait until the stream side is drained and every owed result taken, then idle
    task automatic wait_drained();
        do @(negedge aclk);
        while (tx_stream.size() != 0 || s_tvalid || expected_payload.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] smk;
        logic [31:0] emk;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default markers: noise extremes, empty frame, start marker as payload
        smk = START_MARKER_RST;
        emk = END_MARKER_RST;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_marker(smk, 4);
        push_marker(emk, 4);
        push_marker(smk, 4);
        push_marker(smk, 4);
        push_marker(emk, 4);
        wait_drained();

        // default settings, first without idling then with it
        no_idle = 1'b1;
        fill_random(70, smk, emk, 40);
        wait_drained();
        no_idle = 1'b0;
        fill_random(70, smk, emk, 40);
        wait_drained();

        // random markers, short limit so overflow is common
        smk = $urandom;
        emk = $urandom;
        write_reg(CFG_START_MARKER, smk);
        write_reg(CFG_END_MARKER, emk);
        write_reg(CFG_MAX_LEN, 32'd3);
        fill_random(150, smk, emk, 6);
        wait_drained();

        // equal markers, zero limit behaves as one, unused index ignored
        smk = $urandom;
        emk = smk;
        write_reg(CFG_START_MARKER, smk);
        write_reg(CFG_END_MARKER, emk);
        write_reg(CFG_MAX_LEN, 32'd0);
        write_reg(CFG_UNUSED, $urandom);
        fill_random(120, smk, emk, 3);
        wait_drained();

        // all-zero start, all-ones end, limit above the buffer clips to it
        smk = 32'h0000_0000;
        emk = 32'hFFFF_FFFF;
        write_reg(CFG_START_MARKER, smk);
        write_reg(CFG_END_MARKER, emk);
        write_reg(CFG_MAX_LEN, 32'd8191);
        fill_random(100, smk, emk, 40);
        wait_drained();
        no_idle = 1'b1;
        push_marker(smk, 4);
        push_noise(60);
        push_marker(emk, 4);
        wait_drained();
        no_idle = 1'b0;

        // swapped extremes with the limit at the buffer size
        smk = 32'hFFFF_FFFF;
        emk = 32'h0000_0000;
        write_reg(CFG_START_MARKER, smk);
        write_reg(CFG_END_MARKER, emk);
        write_reg(CFG_MAX_LEN, 32'd4096);
        fill_random(120, smk, emk, 40);
        wait_drained();

        // limit of one; end marker replaced while a frame is open
        smk = $urandom;
        emk = $urandom;
        write_reg(CFG_START_MARKER, smk);
        write_reg(CFG_END_MARKER, emk);
        write_reg(CFG_MAX_LEN, 32'd1);
        push_marker(smk, 4);
        push_byte(8'($urandom));
        wait_drained();
        emk = $urandom;
        write_reg(CFG_END_MARKER, emk);
        push_marker(emk, 4);
        fill_random(120, smk, emk, 4);
        wait_drained();
        repeat (20) @(negedge aclk);

        $display("covered %0d stream bytes and %0d register writes", n_bytes, n_writes);
        $display("results checked: %0d payload, %0d empty frame, %0d overflow",
                 n_data, n_empty, n_ovf);
        if (errors == 0) begin
            $display("** marker_frame_extractor_core: PASSED **");
        end else begin
            $display("** marker_frame_extractor_core: FAILED **");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("timeout with %0d results still owed", expected_payload.size());
        $display("** marker_frame_extractor_core: FAILED **");
        $finish;
    end

endmodule
